// ----- src/ptzfr_pkg.sv -----
// shared types and constants for the ptz frame resync splitter
// used by the controller, the datapath and the top level; no dependencies

package ptzfr_pkg;

  // window and field sizes
  localparam int WIN_DEPTH = 18;
  localparam int FILL_W    = 5;
  localparam int IDX_W     = 5;
  localparam int LIMIT_W   = 12;
  localparam int KIND_W    = 2;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 12'd2048;

  // byte values
  localparam logic [7:0] SYNC_BYTE  = 8'hFF;
  localparam logic [7:0] PRINT_LOW  = 8'd32;
  localparam logic [7:0] PRINT_HIGH = 8'd126;
  localparam logic [7:0] PAD_BYTE   = 8'h00;

  // frame kinds
  localparam logic [KIND_W-1:0] KIND_RESP  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CMD   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;

  // frame lengths
  localparam logic [FILL_W-1:0] LEN_RESP  = 5'd4;
  localparam logic [FILL_W-1:0] LEN_CMD   = 5'd7;
  localparam logic [FILL_W-1:0] LEN_QUERY = 5'd18;

  // long frame scan range: checksum covers bytes 1..16, text check 2..16
  localparam logic [IDX_W-1:0] SCAN_FIRST = 5'd1;
  localparam logic [IDX_W-1:0] SCAN_TEXT  = 5'd2;
  localparam logic [IDX_W-1:0] SCAN_LAST  = 5'd16;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic [7:0]        frame_byte;
    logic [KIND_W-1:0] frame_kind;
    logic              frame_last;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic             append;
    logic             shift;
    logic             clear;
    logic             frame_done;
    logic             scan_clear;
    logic             scan_step;
    logic [IDX_W-1:0] scan_idx;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [FILL_W-1:0] fill;
    logic              head_sync;
    logic              ok_cmd;
    logic              ok_resp;
    logic              ok_query;
    logic              limit_hit;
    logic              can_append;
  } status_t;

endpackage

// ----- src/ptzfr_datapath.sv -----
// datapath: 18-byte window shift register, fill and frame counters,
// frame checks and the serial long-frame scan; depends on ptzfr_pkg

module ptzfr_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  ptzfr_pkg::cmd_t             cmd,
  input  logic [7:0]                  rx_byte,
  input  logic                        cfg_wr_en,
  input  logic [ptzfr_pkg::LIMIT_W-1:0] cfg_wr_data,
  output ptzfr_pkg::status_t          status,
  output logic [7:0]                  head_byte
);
  import ptzfr_pkg::*;

  logic [7:0]         win [WIN_DEPTH];
  logic [FILL_W-1:0]  fill;
  logic [LIMIT_W-1:0] frames_seen;
  logic [LIMIT_W-1:0] max_frames;

  logic [7:0] scan_sum;
  logic       scan_zero;
  logic       scan_bad;

  logic [7:0] sum_cmd;
  logic [7:0] sum_resp;
  logic [7:0] scan_b;

  // window storage: append at fill, shift toward the head
  always_ff @(posedge clk) begin
    if (cmd.append) begin
      win[fill] <= rx_byte;
    end else if (cmd.shift) begin
      for (int i = 0; i < WIN_DEPTH - 1; i++) begin
        win[i] <= win[i+1];
      end
    end
  end

  // fill and frame counters
  always_ff @(posedge clk) begin
    if (rst) begin
      fill        <= '0;
      frames_seen <= '0;
    end else if (cmd.clear) begin
      fill        <= '0;
      frames_seen <= '0;
    end else begin
      if (cmd.append) begin
        fill <= fill + 5'd1;
      end else if (cmd.shift) begin
        fill <= fill - 5'd1;
      end
      if (cmd.frame_done) begin
        frames_seen <= frames_seen + 12'd1;
      end
    end
  end

  // frame limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_frames <= LIMIT_RESET;
    end else if (cfg_wr_en) begin
      max_frames <= cfg_wr_data;
    end
  end

  // serial checksum and text scan for the long frame
  assign scan_b = win[cmd.scan_idx];

  always_ff @(posedge clk) begin
    if (cmd.scan_clear) begin
      scan_sum  <= '0;
      scan_zero <= 1'b0;
      scan_bad  <= 1'b0;
    end else if (cmd.scan_step) begin
      scan_sum <= scan_sum + scan_b;
      if (cmd.scan_idx >= SCAN_TEXT) begin
        if (scan_b == PAD_BYTE) begin
          scan_zero <= 1'b1;
        end else if (scan_zero || !(scan_b inside {[PRINT_LOW:PRINT_HIGH]})) begin
          scan_bad <= 1'b1;
        end
      end
    end
  end

  // short frame checksums
  assign sum_cmd  = win[1] + win[2] + win[3] + win[4] + win[5];
  assign sum_resp = win[1] + win[2];

  // status back to the controller
  always_comb begin
    status.fill       = fill;
    status.head_sync  = (win[0] == SYNC_BYTE);
    status.ok_cmd     = (win[6] == sum_cmd);
    status.ok_resp    = (win[3] == sum_resp);
    status.ok_query   = (win[17] == scan_sum) && !scan_bad;
    status.limit_hit  = (frames_seen >= max_frames);
    status.can_append = (frames_seen < max_frames) && (fill < LEN_QUERY);
  end

  assign head_byte = win[0];

endmodule

// ----- src/ptzfr_ctrl.sv -----
// controller: sequences append, frame decisions, long-frame scan and
// byte-by-byte emission; depends on ptzfr_pkg

module ptzfr_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic                         in_eos,
  output logic                         in_stall,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [ptzfr_pkg::KIND_W-1:0] out_kind,
  output logic                         out_last,
  input  ptzfr_pkg::status_t           status,
  output ptzfr_pkg::cmd_t              cmd
);
  import ptzfr_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DECIDE = 3'd1;
  localparam logic [2:0] ST_SCAN   = 3'd2;
  localparam logic [2:0] ST_LDEC   = 3'd3;
  localparam logic [2:0] ST_EMIT   = 3'd4;
  localparam logic [2:0] ST_FINISH = 3'd5;

  logic [2:0]        state, state_next;
  logic              final_flag, final_flag_next;
  logic [FILL_W-1:0] emit_cnt, emit_cnt_next;
  logic [KIND_W-1:0] kind, kind_next;
  logic [IDX_W-1:0]  scan_idx, scan_idx_next;

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      final_flag <= 1'b0;
      emit_cnt   <= '0;
      kind       <= KIND_RESP;
      scan_idx   <= SCAN_FIRST;
    end else begin
      state      <= state_next;
      final_flag <= final_flag_next;
      emit_cnt   <= emit_cnt_next;
      kind       <= kind_next;
      scan_idx   <= scan_idx_next;
    end
  end

  assign in_stall  = (state != ST_IDLE);
  assign out_valid = (state == ST_EMIT);
  assign out_kind  = kind;
  assign out_last  = (emit_cnt == 5'd1);

  // next state and datapath commands
  always_comb begin
    state_next      = state;
    final_flag_next = final_flag;
    emit_cnt_next   = emit_cnt;
    kind_next       = kind;
    scan_idx_next   = scan_idx;
    cmd             = '0;
    cmd.scan_idx    = scan_idx;

    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.append      = status.can_append;
          final_flag_next = in_eos;
          state_next      = ST_DECIDE;
        end
      end

      ST_DECIDE: begin
        if (status.fill == '0 || status.limit_hit) begin
          state_next = ST_FINISH;
        end else if (!status.head_sync) begin
          cmd.shift = 1'b1;
        end else if (status.fill >= LEN_CMD && status.ok_cmd) begin
          emit_cnt_next = LEN_CMD;
          kind_next     = KIND_CMD;
          state_next    = ST_EMIT;
        end else if (status.fill < LEN_CMD && !final_flag) begin
          state_next = ST_FINISH;
        end else if (status.fill >= LEN_RESP && status.ok_resp) begin
          emit_cnt_next = LEN_RESP;
          kind_next     = KIND_RESP;
          state_next    = ST_EMIT;
        end else if (status.fill >= LEN_QUERY) begin
          cmd.scan_clear = 1'b1;
          scan_idx_next  = SCAN_FIRST;
          state_next     = ST_SCAN;
        end else if (!final_flag) begin
          state_next = ST_FINISH;
        end else begin
          cmd.shift = 1'b1;
        end
      end

      // one window byte per cycle into the long-frame checks
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        scan_idx_next = scan_idx + 5'd1;
        if (scan_idx == SCAN_LAST) begin
          state_next = ST_LDEC;
        end
      end

      ST_LDEC: begin
        if (status.ok_query) begin
          emit_cnt_next = LEN_QUERY;
          kind_next     = KIND_QUERY;
          state_next    = ST_EMIT;
        end else begin
          cmd.shift  = 1'b1;
          state_next = ST_DECIDE;
        end
      end

      // head byte goes out, window shifts on each taken item
      ST_EMIT: begin
        if (!out_stall) begin
          cmd.shift     = 1'b1;
          emit_cnt_next = emit_cnt - 5'd1;
          if (emit_cnt == 5'd1) begin
            cmd.frame_done = 1'b1;
            state_next     = ST_DECIDE;
          end
        end
      end

      ST_FINISH: begin
        cmd.clear  = final_flag;
        state_next = ST_IDLE;
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- src/ptz_frame_resync_splitter_top.sv -----
// top level of the ptz frame resync splitter
// instantiates ptzfr_ctrl and ptzfr_datapath; depends on ptzfr_pkg

// Finds command (7 byte), response (4 byte) and query response (18 byte)
// frames in a received byte stream and sends each accepted frame out one
// byte per item with its kind, sync byte first and frame_last on the checksum.
// One input item is taken per pass; a pass runs an accept step, a window
// decision for each dropped byte and each frame start, the emission of each
// frame byte while out_stall is low, a test of each 18-byte frame (a walk
// over window bytes 1 to 16 one byte at a time for the checksum and text
// check, then a decision), and a closing step. end_of_stream flushes the
// window and clears the frame count in the closing step. max_frames is
// written through cfg_wr_en/cfg_wr_data and should only change while no
// item is in work.

module ptz_frame_resync_splitter_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  ptzfr_pkg::in_item_t           in_item,
  output logic                          out_valid,
  input  logic                          out_stall,
  output ptzfr_pkg::out_item_t          out_item,
  input  logic                          cfg_wr_en,
  input  logic [ptzfr_pkg::LIMIT_W-1:0] cfg_wr_data
);
  import ptzfr_pkg::*;

  cmd_t              cmd;
  status_t           status;
  logic [7:0]        head_byte;
  logic [KIND_W-1:0] out_kind;
  logic              out_last;

  // sequencing
  ptzfr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_eos    (in_item.end_of_stream),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_kind  (out_kind),
    .out_last  (out_last),
    .status    (status),
    .cmd       (cmd)
  );

  // window and checks
  ptzfr_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .rx_byte     (in_item.rx_byte),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .status      (status),
    .head_byte   (head_byte)
  );

  // output item
  always_comb begin
    out_item.frame_byte = head_byte;
    out_item.frame_kind = out_kind;
    out_item.frame_last = out_last;
  end

endmodule
